### rtl/hfd_pkg.sv
// shared types, constants and the crc-8 function of the frame decoder
package hfd_pkg;

   // crc-8, polynomial x^8+x^5+x^4+1, initial value zero
   localparam logic [7:0] CRC_POLY_LOW = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // status bits 1..0 of the reading are cleared before scaling
   localparam logic [15:0] STATUS_MASK = 16'hFFFC;
   localparam logic [15:0] MISMATCH_READING = 16'hFFFF;

   // fixed-point scale factors in hundredths (reading * factor / 2^16) and offsets in hundredths
   localparam int SCALE_W = 15;
   localparam logic [SCALE_W-1:0] TEMP_FACTOR = 15'd17572;
   localparam logic [SCALE_W-1:0] HUM_FACTOR = 15'd12500;
   localparam logic signed [SCALE_W-1:0] TEMP_OFFSET = -15'sd4685;
   localparam logic signed [SCALE_W-1:0] HUM_OFFSET = -15'sd600;
   localparam int PRODUCT_W = 16 + SCALE_W;

   // quantity codes
   localparam logic QTY_TEMP = 1'b0;
   localparam logic QTY_HUM = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // place of the next byte within a frame
   typedef enum logic [1:0] {
      POS_HIGH  = 2'd0,
      POS_LOW   = 2'd1,
      POS_CHECK = 2'd2
   } hfd_pos_type;

   // a checked frame handed from front to back
   typedef struct packed {
      logic [15:0] raw_reading;
      logic [7:0]  computed_crc;
      logic        crc_ok;
      logic        quantity;
   } hfd_frame_type;

   // queue occupancy seen by the neighbours
   typedef struct packed {
      logic full;
      logic empty;
   } hfd_queue_status_type;

   // one byte through the crc, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY_LOW;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/hfd_front.sv
// front end: collects reply bytes, runs the crc and forms checked frames
module hfd_front
   import hfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  logic [7:0]    data_byte,
   input  logic          frame_start,
   input  logic          quantity,
   output logic          frame_push,
   output hfd_frame_type frame_data
);

   hfd_pos_type pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] reading_ff, reading_in;
   logic        qty_ff, qty_in, qty_eff;
   logic        ok;

   // a frame start always restarts at the high byte
   assign pos_eff = frame_start ? POS_HIGH : pos_ff;
   assign qty_eff = frame_start ? quantity : qty_ff;
   assign ok = (crc_ff == data_byte);

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (byte_valid) begin
         unique case (pos_eff)
            POS_LOW:   pos_in = POS_CHECK;
            POS_CHECK: pos_in = POS_HIGH;
            default:   pos_in = POS_LOW;
         endcase
      end
   end

   // datapath updates and frame output
   always_comb begin
      crc_in = crc_ff;
      reading_in = reading_ff;
      qty_in = byte_valid ? qty_eff : qty_ff;
      frame_push = 1'b0;
      frame_data.raw_reading = ok ? reading_ff : MISMATCH_READING;
      frame_data.computed_crc = crc_ff;
      frame_data.crc_ok = ok;
      frame_data.quantity = qty_eff;
      if (byte_valid) begin
         unique case (pos_eff)
            POS_LOW: begin
               reading_in = {reading_ff[15:8], data_byte};
               crc_in = crc8_byte(crc_ff, data_byte);
            end
            POS_CHECK: begin
               frame_push = 1'b1;
            end
            default: begin
               reading_in = {data_byte, 8'h00};
               crc_in = crc8_byte(CRC_INIT, data_byte);
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HIGH;
         crc_ff <= CRC_INIT;
         reading_ff <= '0;
         qty_ff <= QTY_TEMP;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         reading_ff <= reading_in;
         qty_ff <= qty_in;
      end
   end

endmodule

### rtl/hfd_queue.sv
// short frame queue between front and back
module hfd_queue
   import hfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hfd_frame_type        wr_data,
   input  logic                 pop,
   output hfd_frame_type        rd_data,
   output hfd_queue_status_type status
);

   hfd_frame_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign status.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/hfd_back.sv
// back end: scales a checked frame and holds the result for transfer
module hfd_back
   import hfd_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  hfd_queue_status_type        q_status,
   input  hfd_frame_type               q_data,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [SCALE_W-1:0]   rsp_scaled_value,
   output logic [15:0]                 rsp_raw_reading,
   output logic                        rsp_crc_ok,
   output logic [7:0]                  rsp_computed_crc,
   output logic                        rsp_quantity_out
);

   logic                 valid_ff, valid_in;
   hfd_frame_type        frame_ff;
   logic [SCALE_W-1:0]   scaled_hi_ff;
   logic [15:0]          masked;
   logic [SCALE_W-1:0]   factor;
   logic [PRODUCT_W-1:0] product;
   logic signed [SCALE_W-1:0] offset;
   logic [SCALE_W:0]     sum;

   // take a frame whenever the output register is free or leaving
   assign q_pop = !q_status.empty && (!valid_ff || rsp_pop);

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   // constant multiply, upper bits kept (floor of product / 2^16)
   assign masked = q_data.raw_reading & STATUS_MASK;
   assign factor = (q_data.quantity == QTY_HUM) ? HUM_FACTOR : TEMP_FACTOR;
   assign product = PRODUCT_W'(masked) * PRODUCT_W'(factor);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         frame_ff <= q_data;
         scaled_hi_ff <= product[PRODUCT_W-1:16];
      end
   end

   // offset added after the register
   assign offset = (frame_ff.quantity == QTY_HUM) ? HUM_OFFSET : TEMP_OFFSET;
   assign sum = {offset[SCALE_W-1], offset} + {1'b0, scaled_hi_ff};

   assign rsp_empty = !valid_ff;
   assign rsp_scaled_value = sum[SCALE_W-1:0];
   assign rsp_raw_reading = frame_ff.raw_reading;
   assign rsp_crc_ok = frame_ff.crc_ok;
   assign rsp_computed_crc = frame_ff.computed_crc;
   assign rsp_quantity_out = frame_ff.quantity;

endmodule

### rtl/humidity_temp_frame_decoder_top.sv
// top level of the humidity and temperature reply frame decoder
// Takes one reply byte per cycle (high reading byte, low byte, check byte) and
// gives one result per frame on its check byte: the crc-8 check, the reading
// (or 0xFFFF on a mismatch) and the value scaled to hundredths of a degree C
// or of percent RH. A byte is taken every cycle while full is low; full rises
// only when both entries of the two-entry frame queue between the crc front end and the
// scaling back end are occupied, which happens when results are not popped.
// A result passes from its check byte transfer through the frame queue and then
// the output register that follows the constant multiply.
module humidity_temp_frame_decoder_top
   import hfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_frame_start,
   input  logic                       req_quantity,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [SCALE_W-1:0]  rsp_scaled_value,
   output logic [15:0]                rsp_raw_reading,
   output logic                       rsp_crc_ok,
   output logic [7:0]                 rsp_computed_crc,
   output logic                       rsp_quantity_out
);

   logic                 byte_accept;
   logic                 frame_push;
   hfd_frame_type        frame_data;
   hfd_frame_type        q_data;
   hfd_queue_status_type q_status;
   logic                 q_pop;

   // bytes are held off while the frame queue has no room
   assign req_full = q_status.full;
   assign byte_accept = req_push && !req_full;

   hfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_accept),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .quantity    (req_quantity),
      .frame_push  (frame_push),
      .frame_data  (frame_data)
   );

   hfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (frame_push),
      .wr_data (frame_data),
      .pop     (q_pop),
      .rd_data (q_data),
      .status  (q_status)
   );

   hfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_raw_reading  (rsp_raw_reading),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_quantity_out (rsp_quantity_out)
   );

   // a frame is never pushed into a full queue
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(frame_push && q_status.full))
      else $error("frame pushed into full queue");

   // a failed check always carries the mismatch reading
   a_mismatch_reading: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_crc_ok) |-> (rsp_raw_reading == MISMATCH_READING))
      else $error("mismatch result without substitute reading");

   // scaled value stays at or above the offset of its quantity
   a_scaled_floor: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_quantity_out == QTY_HUM ? rsp_scaled_value >= HUM_OFFSET
                                                  : rsp_scaled_value >= TEMP_OFFSET))
      else $error("scaled value below offset");

   // the back end only takes a frame that is there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");

endmodule

### tb/sv/tb_top.sv
// self-checking testbench of the humidity and temperature reply frame decoder
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hfd_pkg::SCALE_W;
   import hfd_pkg::hfd_pos_type;
   import hfd_pkg::POS_HIGH;
   import hfd_pkg::POS_LOW;
   import hfd_pkg::POS_CHECK;
   import hfd_pkg::QTY_TEMP;
   import hfd_pkg::QTY_HUM;

   // crc tap and fixed-point scaling of the reading
   localparam logic [7:0]  CRC_TAP      = 8'h31;
   localparam logic [15:0] READING_MASK = 16'hFFFC;
   localparam logic [15:0] BAD_READING  = 16'hFFFF;
   localparam int          TEMP_GAIN    = 17572;
   localparam int          HUM_GAIN     = 12500;
   localparam int          TEMP_BASE    = -4685;
   localparam int          HUM_BASE     = -600;

   // run shape
   localparam int RANDOM_BYTES   = 1400;
   localparam int IDLE_PERCENT   = 14;
   localparam int REQ_QUIET_LO   = 300;
   localparam int REQ_QUIET_HI   = 550;
   localparam int RSP_QUIET_LO   = 150;
   localparam int RSP_QUIET_HI   = 250;
   localparam int HOLD_AT_RESULT = 100;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_AT_BYTE  = 900;
   localparam int DRAIN_CYCLES   = 8;
   localparam int STALL_LIMIT    = 2000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       quantity;
   } reply_byte_type;

   typedef struct packed {
      logic signed [SCALE_W-1:0] scaled_value;
      logic [15:0]               raw_reading;
      logic                      crc_ok;
      logic [7:0]                computed_crc;
      logic                      quantity_out;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [7:0]                req_data_byte = 8'h00;
   logic                      req_frame_start = 1'b0;
   logic                      req_quantity = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [SCALE_W-1:0] rsp_scaled_value;
   logic [15:0]               rsp_raw_reading;
   logic                      rsp_crc_ok;
   logic [7:0]                rsp_computed_crc;
   logic                      rsp_quantity_out;

   reply_byte_type pending_bytes[$];
   reading_type    expected_readings[$];

   int bytes_sent    = 0;
   int readings_got  = 0;
   int hold_count    = 0;
   int idle_cycles   = 0;
   int mismatches    = 0;

   // decoder state as the predictor sees it
   hfd_pos_type frame_pos   = POS_HIGH;
   logic [7:0]  crc_acc     = 8'h00;
   logic [15:0] reading_acc = 16'h0000;
   logic        qty_latch   = QTY_TEMP;

   humidity_temp_frame_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .req_quantity     (req_quantity),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_raw_reading  (rsp_raw_reading),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_quantity_out (rsp_quantity_out)
   );

   // clock generation
   always #1 clock = ~clock;

   // crc-8 over one byte, msb first
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_TAP) : (c << 1);
      end
      return c;
   endfunction

   // fixed-point scaling with floor rounding
   function automatic logic signed [SCALE_W-1:0] scale_reading(input logic [15:0] raw,
                                                               input logic qty);
      logic [31:0] masked;
      logic [31:0] product;
      int          value;
      masked = {16'h0000, raw & READING_MASK};
      if (qty == QTY_HUM) begin
         product = masked * HUM_GAIN;
         value = HUM_BASE + int'(product >> 16);
      end else begin
         product = masked * TEMP_GAIN;
         value = TEMP_BASE + int'(product >> 16);
      end
      return value[SCALE_W-1:0];
   endfunction

   // one accepted byte through the frame decoder
   task automatic decode_byte(input reply_byte_type item, output bit has_reading,
                              output reading_type reading);
      logic ok;
      has_reading = 1'b0;
      reading = '0;
      if (item.frame_start) begin
         frame_pos = POS_HIGH;
         qty_latch = item.quantity;
      end
      case (frame_pos)
         POS_LOW: begin
            reading_acc = {reading_acc[15:8], item.data_byte};
            crc_acc = crc8_step(crc_acc, item.data_byte);
            frame_pos = POS_CHECK;
         end
         POS_CHECK: begin
            ok = (crc_acc == item.data_byte);
            reading.raw_reading = ok ? reading_acc : BAD_READING;
            reading.scaled_value = scale_reading(reading.raw_reading, qty_latch);
            reading.crc_ok = ok;
            reading.computed_crc = crc_acc;
            reading.quantity_out = qty_latch;
            has_reading = 1'b1;
            frame_pos = POS_HIGH;
         end
         default: begin
            reading_acc = {item.data_byte, 8'h00};
            crc_acc = crc8_step(8'h00, item.data_byte);
            frame_pos = POS_LOW;
         end
      endcase
   endtask

   // one field of a result against its expectation
   function automatic void check_field(input string field, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
         mismatches++;
      end
   endfunction

   task automatic add_byte(input logic [7:0] b, input logic st, input logic q);
      reply_byte_type item;
      item.data_byte = b;
      item.frame_start = st;
      item.quantity = q;
      pending_bytes.push_back(item);
   endtask

   // a whole frame, check byte good or corrupted
   task automatic add_frame(input logic st, input logic q, input logic [15:0] raw,
                            input bit corrupt);
      logic [7:0] chk;
      chk = crc8_step(crc8_step(8'h00, raw[15:8]), raw[7:0]);
      if (corrupt) begin
         chk = chk ^ 8'($urandom_range(255, 1));
      end
      add_byte(raw[15:8], st, q);
      add_byte(raw[7:0], 1'b0, 1'($urandom));
      add_byte(chk, 1'b0, 1'($urandom));
   endtask

   function automatic logic [15:0] pick_reading();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'h00, 8'($urandom)};
         3: return {8'hFF, 8'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   // request side: offer pending bytes, idling and pausing now and then
   always @(negedge clock) begin : req_driver
      bit offer;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         offer = (bytes_sent < pending_bytes.size());
         // pause until every frame so far has come out
         if (bytes_sent == DRAIN_AT_BYTE && expected_readings.size() != 0) begin
            offer = 1'b0;
         end
         if (!(bytes_sent >= REQ_QUIET_LO && bytes_sent < REQ_QUIET_HI) &&
             $urandom_range(99) < IDLE_PERCENT) begin
            offer = 1'b0;
         end
         req_push <= offer;
         if (offer) begin
            req_data_byte <= pending_bytes[bytes_sent].data_byte;
            req_frame_start <= pending_bytes[bytes_sent].frame_start;
            req_quantity <= pending_bytes[bytes_sent].quantity;
         end
      end
   end

   // response side: pop with random stalls and one long hold-off
   always @(negedge clock) begin : rsp_driver
      bit take;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         take = 1'b1;
         if (readings_got == HOLD_AT_RESULT && hold_count < HOLD_CYCLES) begin
            take = 1'b0;
            hold_count <= hold_count + 1;
         end else if (!(readings_got >= RSP_QUIET_LO && readings_got < RSP_QUIET_HI) &&
                      $urandom_range(99) < IDLE_PERCENT) begin
            take = 1'b0;
         end
         rsp_pop <= take;
      end
   end

   // monitor: check result transfers, then predict from byte transfers
   always @(posedge clock) begin : monitor
      reply_byte_type item;
      reading_type    exp_r;
      reading_type    new_r;
      bit             has_r;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected result, expected none actual raw %h", $time,
                        rsp_raw_reading);
               mismatches++;
            end else begin
               exp_r = expected_readings.pop_front();
               check_field("scaled_value", 16'(exp_r.scaled_value), 16'(rsp_scaled_value));
               check_field("raw_reading", exp_r.raw_reading, rsp_raw_reading);
               check_field("crc_ok", 16'(exp_r.crc_ok), 16'(rsp_crc_ok));
               check_field("computed_crc", 16'(exp_r.computed_crc), 16'(rsp_computed_crc));
               check_field("quantity_out", 16'(exp_r.quantity_out), 16'(rsp_quantity_out));
            end
            readings_got <= readings_got + 1;
         end
         if (req_push && !req_full) begin
            item.data_byte = req_data_byte;
            item.frame_start = req_frame_start;
            item.quantity = req_quantity;
            decode_byte(item, has_r, new_r);
            if (has_r) begin
               expected_readings.push_back(new_r);
            end
            bytes_sent <= bytes_sent + 1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int pick;
      reset = 1'b1;

      // extremes of the reading, both quantities, good and bad check bytes
      add_frame(1'b1, QTY_TEMP, 16'h0000, 1'b0);
      add_frame(1'b1, QTY_HUM, 16'hFFFF, 1'b0);
      add_frame(1'b1, QTY_TEMP, 16'hFFFF, 1'b1);
      add_frame(1'b1, QTY_HUM, 16'h1234, 1'b1);
      // back-to-back frame keeps the latched quantity
      add_frame(1'b0, QTY_TEMP, 16'h8003, 1'b0);
      // frame start after one byte drops the partial frame
      add_byte(8'hAB, 1'b1, QTY_HUM);
      add_frame(1'b1, QTY_TEMP, 16'h6A5C, 1'b0);
      // frame start on the check byte position
      add_byte(8'h12, 1'b1, QTY_HUM);
      add_byte(8'h34, 1'b0, QTY_TEMP);
      add_frame(1'b1, QTY_HUM, 16'h7FFF, 1'b0);

      // random part: mostly whole frames, some corrupted, some loose bytes
      while (pending_bytes.size() < RANDOM_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            add_frame($urandom_range(9) != 0, 1'($urandom), pick_reading(), 1'b0);
         end else if (pick < 85) begin
            add_frame($urandom_range(9) != 0, 1'($urandom), pick_reading(), 1'b1);
         end else begin
            repeat ($urandom_range(2, 1)) begin
               add_byte(8'($urandom), 1'($urandom), 1'($urandom));
            end
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_sent < pending_bytes.size() || expected_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
rtl/hfd_pkg.sv
rtl/hfd_front.sv
rtl/hfd_queue.sv
rtl/hfd_back.sv
rtl/humidity_temp_frame_decoder_top.sv
tb/sv/tb_top.sv
